@@ rtl/core/lsrk3_pkg.sv @@
// Shared types, constants and helper functions of the low-storage RK3 block.
// Used by the interfaces' users, the core top level and nothing else external.
package lsrk3_pkg;

	localparam int MODE_W = 12;
	localparam int VAL_W = 32;
	localparam int NSTG = 28;
	localparam int HORNER_STEPS = 10;
	localparam logic [1:0] LAST_STAGE = 2'd2;
	localparam logic [1:0] FIRST_STAGE = 2'd0;
	localparam logic STATUS_OK = 1'b0;
	localparam logic STATUS_UNARMED = 1'b1;
	localparam logic [30:0] ONE_Q30 = 31'd1073741824;
	localparam logic [23:0] LN2_Q24 = 24'd11629080;
	// floor(2^40 / ln2_q24): the quotient estimate is at most one below the true value.
	localparam logic [16:0] INV_LN2_Q40 = 17'd94548;
	localparam int INV_LN2_SH = 40;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [1:0] stg;
		logic nar;
		logic signed [31:0] q_re;
		logic signed [31:0] q_im;
		logic signed [31:0] p_re;
		logic signed [31:0] p_im;
		logic [31:0] c;
		logic signed [32:0] qdt_re;
		logic signed [32:0] qdt_im;
		logic signed [33:0] ag_re;
		logic signed [33:0] ag_im;
		logic [30:0] u;
		logic ubig;
		logic signed [31:0] g_re;
		logic signed [31:0] g_im;
		logic [29:0] x;
		logic signed [31:0] pb_re;
		logic signed [31:0] pb_im;
		logic [6:0] k;
		logic [24:0] r;
		logic [29:0] r6;
		logic [30:0] t;
		logic [30:0] m;
		logic [30:0] e;
		logic signed [31:0] n_re;
		logic signed [31:0] n_im;
	} pipe_t;

	function automatic logic signed [31:0] coef_a(input logic [1:0] s);
		logic signed [31:0] v;
		unique case (s)
			2'd1: v = -32'sd596523236;
			2'd2: v = -32'sd1283457024;
			default: v = 32'sd0;
		endcase
		return v;
	endfunction

	function automatic logic signed [31:0] coef_b(input logic [1:0] s);
		logic signed [31:0] v;
		unique case (s)
			2'd0: v = 32'sd357913941;
			2'd1: v = 32'sd1006632960;
			2'd2: v = 32'sd572662306;
			default: v = 32'sd0;
		endcase
		return v;
	endfunction

	function automatic logic [29:0] coef_f(input logic [1:0] s);
		logic [29:0] v;
		unique case (s)
			2'd0: v = 30'd357913941;
			2'd1: v = 30'd447392427;
			2'd2: v = 30'd268435456;
			default: v = 30'd0;
		endcase
		return v;
	endfunction

	function automatic logic [30:0] horner_recip(input logic [3:0] n);
		logic [30:0] v;
		unique case (n)
			4'd1: v = 31'd1073741824;
			4'd2: v = 31'd536870912;
			4'd3: v = 31'd357913941;
			4'd4: v = 31'd268435456;
			4'd5: v = 31'd214748365;
			4'd6: v = 31'd178956971;
			4'd7: v = 31'd153391689;
			4'd8: v = 31'd134217728;
			4'd9: v = 31'd119304647;
			4'd10: v = 31'd107374182;
			default: v = 31'd0;
		endcase
		return v;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
		logic signed [31:0] res;
		if (v > 35'sd2147483647) begin
			res = 32'sh7fffffff;
		end else if (v < -35'sd2147483648) begin
			res = 32'sh80000000;
		end else begin
			res = v[31:0];
		end
		return res;
	endfunction

endpackage

@@ rtl/core/lsrk3_if.sv @@
// Valid/ready channel interfaces for the request and result sides of the block.
// Standalone; field widths follow the block's fixed item format.
interface lsrk3_in_if;
	logic valid;
	logic ready;
	logic [11:0] mode_index;
	logic signed [31:0] rate_re;
	logic signed [31:0] rate_im;
	logic signed [31:0] value_re;
	logic signed [31:0] value_im;
	logic [31:0] decay_coef;
	logic last_of_pass;
	modport source(output valid, mode_index, rate_re, rate_im, value_re, value_im,
		decay_coef, last_of_pass, input ready);
	modport sink(input valid, mode_index, rate_re, rate_im, value_re, value_im,
		decay_coef, last_of_pass, output ready);
endinterface

interface lsrk3_out_if;
	logic valid;
	logic ready;
	logic [11:0] mode_out;
	logic signed [31:0] new_re;
	logic signed [31:0] new_im;
	logic status;
	logic [1:0] stage_used;
	modport source(output valid, mode_out, new_re, new_im, status, stage_used,
		input ready);
	modport sink(input valid, mode_out, new_re, new_im, status, stage_used,
		output ready);
endinterface

@@ rtl/core/lsrk3_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module lsrk3_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 4096
) (
	input logic clk,
	input logic we,
	input logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

@@ rtl/core/low_storage_rk3_integrating_factor.sv @@
// Low-storage three-stage Runge-Kutta update with an integrating factor, one complex mode per
// request. The per-mode gradient lives in a synchronous RAM that is read when a request is
// taken and written back from the next-to-last pipeline register; results leave from the last,
// and a new request is taken every cycle unless the result side stalls or a hazard holds it. A
// stage 1 or 2 request whose mode maps to the same RAM entry as one still in flight waits until
// that entry has been written, as this read-modify-write loop on the gradient RAM requires. The
// RAM needs no clearing after reset. Write the time step while stage is 0 to arm a pass; the last
// request of stage 2 disarms the block. Depends on lsrk3_pkg, lsrk3_if and lsrk3_ram.
module low_storage_rk3_integrating_factor #(
	parameter int MAX_ITEMS = 4096
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [31:0] cfg_wdata,
	lsrk3_in_if.sink item,
	lsrk3_out_if.source result
);
	localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int MODE_SPAN = 1 << lsrk3_pkg::MODE_W;
	localparam int DIVD = (MAX_ITEMS > MODE_SPAN) ? MODE_SPAN : MAX_ITEMS;
	localparam int MOD_SH = 2 * lsrk3_pkg::MODE_W;
	localparam longint MOD_M = ((64'd1 << MOD_SH) + DIVD - 1) / DIVD;
	localparam int NS = lsrk3_pkg::NSTG;

	logic [31:0] dt_q;
	logic armed_q;
	logic [1:0] stage_q;
	logic [NS:1] pv_q;
	lsrk3_pkg::pipe_t pl_q [1:NS];
	lsrk3_pkg::pipe_t pl_d [1:NS];
	logic [AW-1:0] addr_q [1:NS];

	logic advance;
	logic accept;
	logic hazard;
	logic needs_rd;
	logic [lsrk3_pkg::MODE_W-1:0] quot;
	logic [lsrk3_pkg::MODE_W-1:0] rem;
	logic [AW-1:0] in_addr;
	logic [63:0] rd_data;
	logic ram_we;
	logic [63:0] ram_wdata;

	// Mode index modulo the RAM depth, through a reciprocal multiply.
	always_comb begin
		quot = lsrk3_pkg::MODE_W'((37'(item.mode_index) * 37'(MOD_M)) >> MOD_SH);
		rem = item.mode_index - lsrk3_pkg::MODE_W'(25'(quot) * 25'(DIVD));
		in_addr = AW'(rem);
	end

	always_comb begin
		hazard = 1'b0;
		for (int i = 1; i < NS; i++) begin
			if (pv_q[i] && !pl_q[i].nar && (addr_q[i] == in_addr)) begin
				hazard = 1'b1;
			end
		end
	end

	assign needs_rd = armed_q && (stage_q != lsrk3_pkg::FIRST_STAGE);
	assign advance = !pv_q[NS] || result.ready;
	assign item.ready = advance && !(needs_rd && hazard);
	assign accept = item.valid && item.ready;

	lsrk3_ram #(.WIDTH(64), .DEPTH(MAX_ITEMS)) u_grad_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(addr_q[NS-1]),
		.wdata(ram_wdata),
		.re(accept),
		.raddr(in_addr),
		.rdata(rd_data)
	);

	// Stage, arming and time step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dt_q <= '0;
			armed_q <= 1'b0;
			stage_q <= lsrk3_pkg::FIRST_STAGE;
		end else begin
			if (cfg_we && (stage_q == lsrk3_pkg::FIRST_STAGE)) begin
				dt_q <= cfg_wdata;
				armed_q <= 1'b1;
			end
			if (accept && armed_q && item.last_of_pass) begin
				if (stage_q == lsrk3_pkg::LAST_STAGE) begin
					stage_q <= lsrk3_pkg::FIRST_STAGE;
					armed_q <= 1'b0;
				end else begin
					stage_q <= stage_q + 2'd1;
				end
			end
		end
	end

	// Front of the pipe and the stored-gradient arithmetic.
	always_comb begin
		logic signed [64:0] qp_re, qp_im;
		logic signed [63:0] agp_re, agp_im, bgp_re, bgp_im;
		logic [63:0] cdt;
		logic [39:0] u_full;
		logic [60:0] uf;
		logic [46:0] kq;
		logic signed [33:0] bg_re, bg_im;
		logic [30:0] r0;
		logic [60:0] hp;
		logic [61:0] hq;
		logic [30:0] m2;
		logic signed [63:0] fp_re, fp_im, fg_re, fg_im;
		logic [31:0] tr;
		logic [6:0] km1;

		pl_d[1] = '0;
		pl_d[1].mode = item.mode_index;
		pl_d[1].stg = stage_q;
		pl_d[1].nar = !armed_q;
		pl_d[1].q_re = item.rate_re;
		pl_d[1].q_im = item.rate_im;
		pl_d[1].p_re = item.value_re;
		pl_d[1].p_im = item.value_im;
		pl_d[1].c = item.decay_coef;

		// q*dt, a*g and c*dt
		pl_d[2] = pl_q[1];
		qp_re = pl_q[1].q_re * $signed({1'b0, dt_q});
		qp_im = pl_q[1].q_im * $signed({1'b0, dt_q});
		pl_d[2].qdt_re = 33'((qp_re + (65'sd1 <<< 31)) >>> 32);
		pl_d[2].qdt_im = 33'((qp_im + (65'sd1 <<< 31)) >>> 32);
		agp_re = $signed(rd_data[63:32]) * lsrk3_pkg::coef_a(pl_q[1].stg);
		agp_im = $signed(rd_data[31:0]) * lsrk3_pkg::coef_a(pl_q[1].stg);
		if (pl_q[1].stg == lsrk3_pkg::FIRST_STAGE) begin
			pl_d[2].ag_re = '0;
			pl_d[2].ag_im = '0;
		end else begin
			pl_d[2].ag_re = 34'((agp_re + (64'sd1 <<< 29)) >>> 30);
			pl_d[2].ag_im = 34'((agp_im + (64'sd1 <<< 29)) >>> 30);
		end
		cdt = 64'(pl_q[1].c) * 64'(dt_q);
		u_full = 40'((cdt + 64'd8388608) >> 24);
		pl_d[2].ubig = |u_full[39:31];
		pl_d[2].u = u_full[30:0];

		// New gradient and the scaled exponent argument.
		pl_d[3] = pl_q[2];
		pl_d[3].g_re = lsrk3_pkg::sat32(35'(pl_q[2].ag_re) + 35'(pl_q[2].qdt_re));
		pl_d[3].g_im = lsrk3_pkg::sat32(35'(pl_q[2].ag_im) + 35'(pl_q[2].qdt_im));
		uf = 61'(pl_q[2].u) * 61'(lsrk3_pkg::coef_f(pl_q[2].stg));
		pl_d[3].x = 30'((uf + 61'd536870912) >> 30);

		// p + b*g, and the estimate of x / ln2.
		pl_d[4] = pl_q[3];
		bgp_re = pl_q[3].g_re * lsrk3_pkg::coef_b(pl_q[3].stg);
		bgp_im = pl_q[3].g_im * lsrk3_pkg::coef_b(pl_q[3].stg);
		bg_re = 34'((bgp_re + (64'sd1 <<< 29)) >>> 30);
		bg_im = 34'((bgp_im + (64'sd1 <<< 29)) >>> 30);
		pl_d[4].pb_re = lsrk3_pkg::sat32(35'(pl_q[3].p_re) + 35'(bg_re));
		pl_d[4].pb_im = lsrk3_pkg::sat32(35'(pl_q[3].p_im) + 35'(bg_im));
		kq = 47'(pl_q[3].x) * 47'(lsrk3_pkg::INV_LN2_Q40);
		pl_d[4].k = 7'(kq >> lsrk3_pkg::INV_LN2_SH);

		pl_d[5] = pl_q[4];
		r0 = 31'(pl_q[4].x) - 31'(31'(pl_q[4].k) * 31'(lsrk3_pkg::LN2_Q24));
		pl_d[5].r = r0[24:0];

		// The estimate may be one short; correct it once.
		pl_d[6] = pl_q[5];
		if (pl_q[5].r >= 25'(lsrk3_pkg::LN2_Q24)) begin
			pl_d[6].k = pl_q[5].k + 7'd1;
			pl_d[6].r6 = {24'(pl_q[5].r - 25'(lsrk3_pkg::LN2_Q24)), 6'd0};
		end else begin
			pl_d[6].r6 = {pl_q[5].r[23:0], 6'd0};
		end
		pl_d[6].t = lsrk3_pkg::ONE_Q30;

		// Horner evaluation of exp(-r), two registered multiplies per term.
		for (int j = 0; j < lsrk3_pkg::HORNER_STEPS; j++) begin
			pl_d[7+2*j] = pl_q[6+2*j];
			hp = 61'(pl_q[6+2*j].r6) * 61'(pl_q[6+2*j].t);
			pl_d[7+2*j].m = 31'((hp + 61'd536870912) >> 30);
			pl_d[8+2*j] = pl_q[7+2*j];
			hq = 62'(pl_q[7+2*j].m) *
				62'(lsrk3_pkg::horner_recip(4'(lsrk3_pkg::HORNER_STEPS - j)));
			m2 = 31'((hq + 62'd536870912) >> 30);
			pl_d[8+2*j].t = lsrk3_pkg::ONE_Q30 - m2;
		end

		// Factor 2^-k, then scale p and g.
		pl_d[NS-1] = pl_q[NS-2];
		km1 = pl_q[NS-2].k - 7'd1;
		tr = (32'(pl_q[NS-2].t) + (32'd1 << km1[4:0])) >> pl_q[NS-2].k[4:0];
		if (pl_q[NS-2].ubig || (pl_q[NS-2].k >= 7'd31)) begin
			pl_d[NS-1].e = '0;
		end else if (pl_q[NS-2].k == 7'd0) begin
			pl_d[NS-1].e = pl_q[NS-2].t;
		end else begin
			pl_d[NS-1].e = tr[30:0];
		end

		pl_d[NS] = pl_q[NS-1];
		fp_re = pl_q[NS-1].pb_re * $signed({1'b0, pl_q[NS-1].e});
		fp_im = pl_q[NS-1].pb_im * $signed({1'b0, pl_q[NS-1].e});
		fg_re = pl_q[NS-1].g_re * $signed({1'b0, pl_q[NS-1].e});
		fg_im = pl_q[NS-1].g_im * $signed({1'b0, pl_q[NS-1].e});
		ram_wdata = {32'((fg_re + (64'sd1 <<< 29)) >>> 30),
			32'((fg_im + (64'sd1 <<< 29)) >>> 30)};
		if (pl_q[NS-1].nar) begin
			pl_d[NS].n_re = pl_q[NS-1].p_re;
			pl_d[NS].n_im = pl_q[NS-1].p_im;
		end else begin
			pl_d[NS].n_re = 32'((fp_re + (64'sd1 <<< 29)) >>> 30);
			pl_d[NS].n_im = 32'((fp_im + (64'sd1 <<< 29)) >>> 30);
		end
	end

	assign ram_we = advance && pv_q[NS-1] && !pl_q[NS-1].nar;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_q <= '0;
		end else if (advance) begin
			pv_q <= {pv_q[NS-1:1], accept};
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			pl_q[1] <= pl_d[1];
			addr_q[1] <= in_addr;
			for (int i = 2; i <= NS; i++) begin
				pl_q[i] <= pl_d[i];
				addr_q[i] <= addr_q[i-1];
			end
		end
	end

	assign result.valid = pv_q[NS];
	assign result.mode_out = pl_q[NS].mode;
	assign result.new_re = pl_q[NS].n_re;
	assign result.new_im = pl_q[NS].n_im;
	assign result.status = pl_q[NS].nar ? lsrk3_pkg::STATUS_UNARMED : lsrk3_pkg::STATUS_OK;
	assign result.stage_used = pl_q[NS].stg;

	// A gradient read that is needed (armed, stage 1 or 2) never targets the entry being written in the same cycle.
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && accept && needs_rd) |-> (addr_q[NS-1] != in_addr))
		else $error("gradient read and write collide on one entry");

	a_arm_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(armed_q) |-> ($past(cfg_we) && ($past(stage_q) == lsrk3_pkg::FIRST_STAGE)))
		else $error("block armed without a time step write in stage 0");

	a_disarm_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(armed_q) |-> (stage_q == lsrk3_pkg::FIRST_STAGE))
		else $error("block disarmed outside the end of a step");

	a_stage_range: assert property (@(posedge clk) disable iff (!arst_n)
		stage_q != 2'd3)
		else $error("stage counter out of range");
endmodule
